@@ sv/afld_pkg.sv @@
// ----------------------------------------------------------------------------
// AGC frame level detector package
// Shared types, register indexes and helpers for the level detector.
// ----------------------------------------------------------------------------
package afld_pkg;

	localparam int SMP_W  = 16;
	localparam int MAG_W  = 15;
	localparam int SQ_W   = 31;
	localparam int SUM_W  = 41;
	localparam int LEN_W  = 11;
	localparam int COEF_W = 17;
	localparam int ACC_W  = 32;

	localparam logic [1:0] REG_FRAME_LENGTH = 2'd0;
	localparam logic [1:0] REG_ENV_COEFF    = 2'd1;
	localparam logic [1:0] REG_RMS_COEFF    = 2'd2;

	typedef struct packed {
		logic signed [SMP_W-1:0] raw_sample;
		logic signed [SMP_W-1:0] shaped_sample;
	} in_item_t;

	typedef struct packed {
		logic [MAG_W-1:0]  raw_peak;
		logic [SQ_W-1:0]   raw_mean_square;
		logic [MAG_W-1:0]  shaped_peak;
		logic [SQ_W-1:0]   shaped_mean_square;
		logic [15:0]       smoothed_level;
		logic [MAG_W-1:0]  envelope_level;
	} out_item_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic sample_en;
		logic div_start;
		logic div_step;
		logic sqrt_start;
		logic sqrt_step;
		logic rms_update;
		logic clear;
	} afld_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic frame_done;
	} afld_sts_t;

	// Saturated magnitude of a signed sample.
	function automatic logic [MAG_W-1:0] sat_mag(input logic signed [SMP_W-1:0] x);
		logic [SMP_W-1:0] m;
		m = x[SMP_W-1] ? SMP_W'(-x) : SMP_W'(x);
		if (m[SMP_W-1])
			return {MAG_W{1'b1}};
		return m[MAG_W-1:0];
	endfunction

	// Clamp a coefficient into the legal Q16 range.
	function automatic logic [COEF_W-1:0] clamp_coeff(input logic [COEF_W-1:0] c);
		if (c < COEF_W'(66))
			return COEF_W'(66);
		if (c > COEF_W'(65536))
			return COEF_W'(65536);
		return c;
	endfunction

endpackage

@@ sv/agc_frame_level_detector_core.sv @@
// ----------------------------------------------------------------------------
// AGC frame level detector core
// Sequence: a sample that does not close a frame is taken on acceptance; after
// the last sample of a frame the block runs the 41-step divider, the square
// root load and 32 steps, and smoothing, then presents the result request.
// Throughput: one sample per cycle within a frame; intake stops from the last
// sample of a frame until its result request is accepted.
// Reset: asynchronous, clears all accumulators and loads default registers.
// ----------------------------------------------------------------------------
module agc_frame_level_detector_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  afld_pkg::in_item_t   in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output afld_pkg::out_item_t  out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [1:0]           cfg_index,
	input  logic [16:0]          cfg_data
);
	import afld_pkg::*;

	logic [LEN_W-1:0]  len_q;
	logic [COEF_W-1:0] env_coeff_q, rms_coeff_q;
	logic [LEN_W-1:0]  len_eff;
	afld_cmd_t         cmd;
	afld_sts_t         sts;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= LEN_W'(256);
			env_coeff_q <= COEF_W'(65536);
			rms_coeff_q <= COEF_W'(65536);
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_FRAME_LENGTH: len_q       <= cfg_data[LEN_W-1:0];
				REG_ENV_COEFF:    env_coeff_q <= cfg_data;
				REG_RMS_COEFF:    rms_coeff_q <= cfg_data;
				default:          ;
			endcase
		end
	end

	// Effective frame length: zero means one, capped at 1024.
	always_comb begin
		len_eff = len_q;
		if (len_q == '0)
			len_eff = LEN_W'(1);
		else if (len_q > LEN_W'(1024))
			len_eff = LEN_W'(1024);
	end

	afld_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	afld_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.item      (in_data),
		.len       (len_eff),
		.env_coeff (env_coeff_q),
		.rms_coeff (rms_coeff_q),
		.result    (out_data)
	);

endmodule

@@ sv/afld_datapath.sv @@
// ----------------------------------------------------------------------------
// AGC frame level detector datapath
// Peak and energy accumulators, envelope filter, bit-serial divider,
// digit-serial square root and RMS smoothing filter.
// ----------------------------------------------------------------------------
module afld_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  afld_pkg::afld_cmd_t cmd,
	output afld_pkg::afld_sts_t sts,
	input  afld_pkg::in_item_t  item,
	input  logic [10:0]         len,
	input  logic [16:0]         env_coeff,
	input  logic [16:0]         rms_coeff,
	output afld_pkg::out_item_t result
);
	import afld_pkg::*;

	logic [MAG_W-1:0]  raw_peak_q, shp_peak_q;
	logic [SUM_W-1:0]  raw_sum_q, shp_sum_q;
	logic [SUM_W-1:0]  raw_sum_nx, shp_sum_nx;
	logic [LEN_W-1:0]  idx_q;
	logic [ACC_W-1:0]  env_q, rms_q;
	logic [MAG_W-1:0]  ra, sa;
	logic [31:0]       raw_sq, shp_sq;
	logic [ACC_W-1:0]  env_tgt, env_next, rms_next;
	logic [LEN_W-1:0]  idx_inc;

	// Restoring divider state for both sums.
	logic [SUM_W-1:0]  raw_rem_q, shp_rem_q, raw_quo_q, shp_quo_q;
	logic [SUM_W-1:0]  raw_t, shp_t;

	// Square root state.
	logic [63:0]       sq_x_q;
	logic [31:0]       sq_r_q;
	logic [33:0]       sq_rem_q;
	logic [33:0]       sq_trial;
	logic [33:0]       sq_rem_sh;

	// One-pole update: acc moves toward target by c*(t-acc) >> 16, floored.
	function automatic logic [ACC_W-1:0] one_pole(input logic [ACC_W-1:0] acc,
		input logic [ACC_W-1:0] tgt, input logic [COEF_W-1:0] c);
		logic [COEF_W-1:0] cc;
		logic [48:0]       p;
		cc = clamp_coeff(c);
		if (tgt >= acc) begin
			p = 49'(tgt - acc) * 49'(cc);
			return acc + p[47:16];
		end
		p = 49'(acc - tgt) * 49'(cc) + 49'(16'hFFFF);
		return acc - p[47:16];
	endfunction

	assign ra         = sat_mag(item.raw_sample);
	assign sa         = sat_mag(item.shaped_sample);
	assign raw_sq     = 32'($signed(item.raw_sample) * $signed(item.raw_sample));
	assign shp_sq     = 32'($signed(item.shaped_sample) * $signed(item.shaped_sample));
	assign raw_sum_nx = raw_sum_q + SUM_W'(raw_sq);
	assign shp_sum_nx = shp_sum_q + SUM_W'(shp_sq);
	assign env_tgt    = {1'b0, sa, 16'h0};
	assign env_next   = one_pole(env_q, env_tgt, env_coeff);
	assign rms_next   = one_pole(rms_q, sq_r_q, rms_coeff);
	assign idx_inc    = idx_q + LEN_W'(1);
	assign sts.frame_done = (idx_inc >= len);

	// Per-sample accumulation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_peak_q <= '0;
			shp_peak_q <= '0;
			raw_sum_q  <= '0;
			shp_sum_q  <= '0;
			idx_q      <= '0;
			env_q      <= '0;
		end else if (cmd.clear) begin
			raw_peak_q <= '0;
			shp_peak_q <= '0;
			raw_sum_q  <= '0;
			shp_sum_q  <= '0;
			idx_q      <= '0;
		end else if (cmd.sample_en) begin
			if (ra > raw_peak_q)
				raw_peak_q <= ra;
			if (sa > shp_peak_q)
				shp_peak_q <= sa;
			raw_sum_q <= raw_sum_nx;
			shp_sum_q <= shp_sum_nx;
			idx_q     <= idx_inc;
			env_q     <= env_next;
		end
	end

	// Bit-serial restoring division, one quotient bit per cycle per sum.
	// The division starts with the sample that closes the frame, so the
	// dividends include that sample's squares.
	assign raw_t = {raw_rem_q[SUM_W-2:0], raw_quo_q[SUM_W-1]};
	assign shp_t = {shp_rem_q[SUM_W-2:0], shp_quo_q[SUM_W-1]};

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			raw_rem_q <= '0;
			shp_rem_q <= '0;
			raw_quo_q <= raw_sum_nx;
			shp_quo_q <= shp_sum_nx;
		end else if (cmd.div_step) begin
			if (raw_t >= SUM_W'(len)) begin
				raw_rem_q <= raw_t - SUM_W'(len);
				raw_quo_q <= {raw_quo_q[SUM_W-2:0], 1'b1};
			end else begin
				raw_rem_q <= raw_t;
				raw_quo_q <= {raw_quo_q[SUM_W-2:0], 1'b0};
			end
			if (shp_t >= SUM_W'(len)) begin
				shp_rem_q <= shp_t - SUM_W'(len);
				shp_quo_q <= {shp_quo_q[SUM_W-2:0], 1'b1};
			end else begin
				shp_rem_q <= shp_t;
				shp_quo_q <= {shp_quo_q[SUM_W-2:0], 1'b0};
			end
		end
	end

	// Digit-serial square root of the shaped mean << 32, two radicand bits per cycle.
	assign sq_rem_sh = {sq_rem_q[31:0], sq_x_q[63:62]};
	assign sq_trial  = {sq_r_q, 2'b01};

	always_ff @(posedge clk) begin
		if (cmd.sqrt_start) begin
			sq_x_q   <= {shp_quo_q[31:0], 32'h0};
			sq_r_q   <= '0;
			sq_rem_q <= '0;
		end else if (cmd.sqrt_step) begin
			sq_x_q <= {sq_x_q[61:0], 2'b00};
			if (sq_rem_sh >= sq_trial) begin
				sq_rem_q <= sq_rem_sh - sq_trial;
				sq_r_q   <= {sq_r_q[30:0], 1'b1};
			end else begin
				sq_rem_q <= sq_rem_sh;
				sq_r_q   <= {sq_r_q[30:0], 1'b0};
			end
		end
	end

	// Smoothed RMS and the frame result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rms_q <= '0;
		else if (cmd.rms_update)
			rms_q <= rms_next;
	end

	always_ff @(posedge clk) begin
		if (cmd.rms_update) begin
			result.raw_peak           <= raw_peak_q;
			result.raw_mean_square    <= raw_quo_q[SQ_W-1:0];
			result.shaped_peak        <= shp_peak_q;
			result.shaped_mean_square <= shp_quo_q[SQ_W-1:0];
			result.smoothed_level     <= rms_next[31:16];
			result.envelope_level     <= env_q[30:16];
		end
	end

endmodule

@@ sv/afld_ctrl.sv @@
// ----------------------------------------------------------------------------
// AGC frame level detector controller
// Sequences sample intake, frame-end division, square root and output.
// ----------------------------------------------------------------------------
module afld_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  afld_pkg::afld_sts_t sts,
	output afld_pkg::afld_cmd_t cmd
);
	import afld_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_DIV  = 5'b00010,
		ST_SQRT = 5'b00100,
		ST_RMS  = 5'b01000,
		ST_OUT  = 5'b10000
	} state_t;

	state_t     state_q;
	logic [5:0] cnt_q;
	logic       accept;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign accept    = in_valid && in_ready;

	// Command decode. The first square root cycle loads the finished quotient.
	always_comb begin
		cmd            = '0;
		cmd.sample_en  = accept;
		cmd.div_start  = accept && sts.frame_done;
		cmd.div_step   = (state_q == ST_DIV);
		cmd.sqrt_start = (state_q == ST_SQRT) && (cnt_q == 6'd0);
		cmd.sqrt_step  = (state_q == ST_SQRT) && (cnt_q != 6'd0);
		cmd.rms_update = (state_q == ST_RMS);
		cmd.clear      = (state_q == ST_RMS);
	end

	// State sequencing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (accept && sts.frame_done)
						state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'(SUM_W-1)) begin
						cnt_q   <= '0;
						state_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd32)
						state_q <= ST_RMS;
				end
				ST_RMS:  state_q <= ST_OUT;
				ST_OUT: begin
					if (out_ready)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
